// ----- hw/rtl/depth_pixel_to_world_point_top_macros.svh -----
// Assertion macros shared by the depth pixel to world point block.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_TOP_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever a holds, b holds too.
`define DPWP_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dpwp assertion failed");

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define DPWP_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dpwp assertion failed");

`else

`define DPWP_ASSERT_IMPLIES(label, clk, rst, a, b)
`define DPWP_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ----- hw/rtl/dpwp_pkg.sv -----
// Types, constants and helpers of the depth pixel to world point block.
package dpwp_pkg;

  localparam int STRIDE = 3;
  localparam int PIX_W  = 12;

  // Remainder by STRIDE: multiply by a truncated reciprocal, then one correction.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] STRIDE_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / STRIDE);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CFG_ROT_ROW_X     = 3'd0,
    CFG_ROT_ROW_Y     = 3'd1,
    CFG_ROT_ROW_Z     = 3'd2,
    CFG_TRANSLATION   = 3'd3,
    CFG_INV_FOCAL     = 3'd4,
    CFG_PRINCIPAL_PT  = 3'd5,
    CFG_DEPTH_MIN     = 3'd6,
    CFG_DEPTH_MAX     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;
    logic [15:0]      depth_mm;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         point_red;
    logic [7:0]         point_green;
    logic [7:0]         point_blue;
  } point_t;

  typedef struct packed {
    logic [47:0] rot_row_x;
    logic [47:0] rot_row_y;
    logic [47:0] rot_row_z;
    logic [62:0] translation;
    logic [63:0] inv_focal;
    logic [31:0] principal_point;
    logic [15:0] depth_min;
    logic [15:0] depth_max;
  } cfg_t;

  localparam logic [47:0] ROT_ROW_X_RST = 48'h4000_0000_0000;
  localparam logic [47:0] ROT_ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [47:0] ROT_ROW_Z_RST = 48'h0000_0000_4000;
  localparam logic [15:0] DEPTH_MIN_RST = 16'd10;
  localparam logic [15:0] DEPTH_MAX_RST = 16'd10000;

  // Queue status seen by the front end.
  typedef struct packed {
    logic can_push;
    logic full;
  } queue_stat_t;

  // True when v is a multiple of STRIDE.
  function automatic logic stride_hit(input logic [PIX_W-1:0] v);
    logic [PIX_W+RECIP_W-1:0] prod;
    logic [PIX_W-1:0]         q;
    logic [PIX_W:0]           r;
    prod = (PIX_W+RECIP_W)'(v) * (PIX_W+RECIP_W)'(STRIDE_RECIP);
    q    = prod[RECIP_SHIFT +: PIX_W];
    r    = {1'b0, v} - (PIX_W+1)'(q * (PIX_W+1)'(STRIDE));
    return (r == '0) || (r == (PIX_W+1)'(STRIDE));
  endfunction

endpackage

// ----- hw/rtl/dpwp_front.sv -----
// Front end: takes pixel requests, applies stride and depth window, feeds the queue.
module dpwp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dpwp_pkg::pixel_t      pixel,
  input  logic [15:0]           depth_min,
  input  logic [15:0]           depth_max,
  input  dpwp_pkg::queue_stat_t q_stat,
  output logic                  busy,
  output logic                  push,
  output dpwp_pkg::pixel_t      push_data
);

  logic             fr_valid;
  logic             fr_keep;
  dpwp_pkg::pixel_t fr_pix;
  logic             accept;
  logic             keep_next;
  logic             stall;

  assign stall  = fr_valid && fr_keep && !q_stat.can_push;
  assign busy   = stall;
  assign accept = start && !busy;

  assign keep_next = dpwp_pkg::stride_hit(pixel.pixel_row) &&
                     dpwp_pkg::stride_hit(pixel.pixel_col) &&
                     (pixel.depth_mm >= depth_min) &&
                     (pixel.depth_mm <= depth_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
      fr_keep  <= 1'b0;
    end else if (accept) begin
      fr_valid <= 1'b1;
      fr_keep  <= keep_next;
    end else if (!stall) begin
      fr_valid <= 1'b0;
      fr_keep  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_pix <= pixel;
    end
  end

  assign push      = fr_valid && fr_keep && q_stat.can_push;
  assign push_data = fr_pix;

endmodule

// ----- hw/rtl/dpwp_queue.sv -----
// Short request queue between the front and back ends.
module dpwp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dpwp_pkg::pixel_t      push_data,
  input  logic                  pop_ready,
  output dpwp_pkg::queue_stat_t stat,
  output logic                  pop_valid,
  output dpwp_pkg::pixel_t      pop_data
);

  localparam int PTR_W = $clog2(dpwp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dpwp_pkg::QUEUE_DEPTH + 1);

  dpwp_pkg::pixel_t entries [dpwp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic             do_push;

  assign pop_valid     = (count != '0);
  assign pop           = pop_valid && pop_ready;
  assign stat.full     = (count == CNT_W'(dpwp_pkg::QUEUE_DEPTH));
  assign stat.can_push = !stat.full || pop;
  assign do_push       = push && stat.can_push;
  assign pop_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dpwp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dpwp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/dpwp_back.sv -----
// Back end: six-stage pinhole lift and camera-to-world transform.
module dpwp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dpwp_pkg::pixel_t in_pix,
  input  dpwp_pkg::cfg_t   cfg,
  output logic             out_valid,
  output dpwp_pkg::point_t out_point
);

  localparam logic signed [42:0] W_MAX = 43'sd2147483647;
  localparam logic signed [42:0] W_MIN = -43'sd2147483648;

  logic va, vb, vc, vd, ve, vf;

  dpwp_pkg::pixel_t a_pix, b_pix, c_pix, d_pix, e_pix;

  // stage A: |16*col - cx| * depth
  logic signed [17:0] dx, dy;
  logic [15:0]        mag_x, mag_y;
  logic [31:0]        a_mdx, a_mdy;
  logic               a_negx, a_negy;

  // stage B: times reciprocal focal length
  logic [63:0] b_px, b_py;
  logic        b_negx, b_negy;

  // stage C: floor to Q.8 camera point
  logic signed [37:0] c_xc, c_yc;
  logic [23:0]        c_zc;

  // stage D: rotation products, stage E: row sums
  logic [47:0]        rot [3];
  logic [20:0]        tr  [3];
  logic signed [53:0] d_p0 [3];
  logic signed [53:0] d_p1 [3];
  logic signed [53:0] d_p2 [3];
  logic signed [55:0] e_sum [3];

  // stage F: shift, translate, saturate
  logic signed [55:0] f_sh [3];
  logic signed [42:0] f_w  [3];
  logic signed [31:0] f_sat [3];

  function automatic logic signed [37:0] lift_fin(input logic [63:0] prod, input logic neg);
    logic [36:0] q;
    q = {1'b0, prod[63:28]} + 37'(neg && (prod[27:0] != '0));
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  assign rot[0] = cfg.rot_row_x;
  assign rot[1] = cfg.rot_row_y;
  assign rot[2] = cfg.rot_row_z;
  assign tr[0]  = cfg.translation[62:42];
  assign tr[1]  = cfg.translation[41:21];
  assign tr[2]  = cfg.translation[20:0];

  assign dx    = $signed({2'b00, in_pix.pixel_col, 4'b0000}) -
                 $signed({2'b00, cfg.principal_point[31:16]});
  assign dy    = $signed({2'b00, in_pix.pixel_row, 4'b0000}) -
                 $signed({2'b00, cfg.principal_point[15:0]});
  assign mag_x = dx[17] ? 16'(-dx) : dx[15:0];
  assign mag_y = dy[17] ? 16'(-dy) : dy[15:0];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      f_sh[a] = e_sum[a] >>> 14;
      f_w[a]  = 43'(f_sh[a]) + 43'($signed({tr[a], 8'h00}));
      if (f_w[a] > W_MAX) begin
        f_sat[a] = 32'(W_MAX);
      end else if (f_w[a] < W_MIN) begin
        f_sat[a] = 32'(W_MIN);
      end else begin
        f_sat[a] = 32'(f_w[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    a_pix  <= in_pix;
    a_mdx  <= mag_x * in_pix.depth_mm;
    a_mdy  <= mag_y * in_pix.depth_mm;
    a_negx <= dx[17];
    a_negy <= dy[17];

    b_pix  <= a_pix;
    b_px   <= a_mdx * cfg.inv_focal[63:32];
    b_py   <= a_mdy * cfg.inv_focal[31:0];
    b_negx <= a_negx;
    b_negy <= a_negy;

    c_pix <= b_pix;
    c_xc  <= lift_fin(b_px, b_negx);
    c_yc  <= lift_fin(b_py, b_negy);
    c_zc  <= {b_pix.depth_mm, 8'h00};

    d_pix <= c_pix;
    for (int a = 0; a < 3; a++) begin
      d_p0[a] <= $signed(rot[a][47:32]) * c_xc;
      d_p1[a] <= $signed(rot[a][31:16]) * c_yc;
      d_p2[a] <= $signed(rot[a][15:0]) * $signed({1'b0, c_zc});
    end

    e_pix <= d_pix;
    for (int a = 0; a < 3; a++) begin
      e_sum[a] <= 56'(d_p0[a]) + 56'(d_p1[a]) + 56'(d_p2[a]);
    end

    out_point.world_x     <= f_sat[0];
    out_point.world_y     <= f_sat[1];
    out_point.world_z     <= f_sat[2];
    out_point.point_red   <= e_pix.red;
    out_point.point_green <= e_pix.green;
    out_point.point_blue  <= e_pix.blue;
  end

  assign out_valid = vf;

endmodule

// ----- hw/rtl/depth_pixel_to_world_point_top.sv -----
// Top level of the depth pixel to world point block.
//
//  channel   | signals                          | direction | handshake
//  ----------+----------------------------------+-----------+-------------------------
//  pixel     | start, busy, pixel               | in        | taken when start & !busy
//  point     | point_valid, point               | out       | one-cycle strobe
//  config    | cfg_we, cfg_index, cfg_data      | in        | written when cfg_we
//
// One pixel request is taken every clock while busy is low. A kept pixel's
// point passes the front register, one queue slot and the six back-end
// stages in turn; the second back-end stage is the 32x32 reciprocal multiply.
// Dropped pixels (off stride or outside the depth window) leave no point.
// rst is synchronous; it clears all valid state and loads the register
// defaults (identity rotation, depth window 10..10000 mm).
// The receiver cannot stall point, so the back end drains the queue every
// cycle and busy only rises if the queue fills.
`include "depth_pixel_to_world_point_top_macros.svh"

module depth_pixel_to_world_point_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dpwp_pkg::pixel_t pixel,
  output logic             point_valid,
  output dpwp_pkg::point_t point,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  dpwp_pkg::cfg_t        cfg;
  dpwp_pkg::queue_stat_t q_stat;
  dpwp_pkg::pixel_t      push_data;
  dpwp_pkg::pixel_t      pop_data;
  logic                  push;
  logic                  pop_valid;

  // Register file: plain writes, unused upper bits dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_row_x       <= dpwp_pkg::ROT_ROW_X_RST;
      cfg.rot_row_y       <= dpwp_pkg::ROT_ROW_Y_RST;
      cfg.rot_row_z       <= dpwp_pkg::ROT_ROW_Z_RST;
      cfg.translation     <= '0;
      cfg.inv_focal       <= '0;
      cfg.principal_point <= '0;
      cfg.depth_min       <= dpwp_pkg::DEPTH_MIN_RST;
      cfg.depth_max       <= dpwp_pkg::DEPTH_MAX_RST;
    end else if (cfg_we) begin
      case (dpwp_pkg::cfg_reg_e'(cfg_index))
        dpwp_pkg::CFG_ROT_ROW_X:    cfg.rot_row_x       <= cfg_data[47:0];
        dpwp_pkg::CFG_ROT_ROW_Y:    cfg.rot_row_y       <= cfg_data[47:0];
        dpwp_pkg::CFG_ROT_ROW_Z:    cfg.rot_row_z       <= cfg_data[47:0];
        dpwp_pkg::CFG_TRANSLATION:  cfg.translation     <= cfg_data[62:0];
        dpwp_pkg::CFG_INV_FOCAL:    cfg.inv_focal       <= cfg_data;
        dpwp_pkg::CFG_PRINCIPAL_PT: cfg.principal_point <= cfg_data[31:0];
        dpwp_pkg::CFG_DEPTH_MIN:    cfg.depth_min       <= cfg_data[15:0];
        dpwp_pkg::CFG_DEPTH_MAX:    cfg.depth_max       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front end: stride and depth window test, one register stage.
  dpwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pixel     (pixel),
    .depth_min (cfg.depth_min),
    .depth_max (cfg.depth_max),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  // Two-entry queue decoupling front and back.
  dpwp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop_ready (1'b1),
    .stat      (q_stat),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  // Back end: lift and transform pipeline, never stalls.
  dpwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_pix    (pop_data),
    .cfg       (cfg),
    .out_valid (point_valid),
    .out_point (point)
  );

  // The back end pops every cycle, so the queue never backs up.
  `DPWP_ASSERT_IMPLIES(a_never_busy, clk, rst, 1'b1, !busy)

  // Every point traces back to an earlier taken request.
  `DPWP_ASSERT_IMPLIES(a_point_has_request, clk, rst, point_valid,
                       $past(start && !busy, 8))

  // A request outside the depth window yields no point.
  `DPWP_ASSERT_IMPLIES(a_depth_drop, clk, rst,
                       $past(start && !busy && ((pixel.depth_mm < cfg.depth_min) ||
                             (pixel.depth_mm > cfg.depth_max)), 8),
                       !point_valid)

endmodule
